[rtl/core/albd_pkg.sv]
// Shared types, constants and range-table decode functions of the ladder button decoder.
package albd_pkg;

  // Fixed field widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int SPR_W      = 5;
  localparam int THR_W      = 10;
  localparam int IDX_W      = 4;
  localparam int CODE_W     = 3;
  localparam int LUT_W      = 16;

  // Register reset values and the legal span of the sample count.
  localparam logic [SPR_W-1:0] SPR_RESET = 5'd5;
  localparam logic [THR_W-1:0] THR_RESET = 10'd8;
  localparam logic [SPR_W-1:0] SPR_MIN   = 5'd2;
  localparam logic [SPR_W-1:0] SPR_MAX   = 5'd16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES_PER_READ    = 2'd0,
    CFG_STABILITY_THRESHOLD = 2'd1
  } cfg_idx_t;

  // Channel selection.
  localparam logic CH_ACTION    = 1'b0;
  localparam logic CH_DIRECTION = 1'b1;

  typedef enum logic [CODE_W-1:0] {
    ACT_NONE     = 3'd0,
    ACT_START    = 3'd1,
    ACT_RED      = 3'd2,
    ACT_BLUE     = 3'd3,
    ACT_RED_BLUE = 3'd4
  } act_code_t;

  typedef enum logic [CODE_W-1:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_code_t;

  // Configuration register contents.
  typedef struct packed {
    logic [SPR_W-1:0] samples_per_read;
    logic [THR_W-1:0] stability_threshold;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic      next_channel;
    logic      done_res;
    logic      invalid;
    act_code_t action_button;
    dir_code_t direction_button;
  } res_t;

  typedef struct packed {
    logic [LUT_W-1:0] lo;
    logic [LUT_W-1:0] hi;
    act_code_t        code;
  } act_range_t;

  typedef struct packed {
    logic [LUT_W-1:0] lo;
    logic [LUT_W-1:0] hi;
    dir_code_t        code;
  } dir_range_t;

  localparam int TABLE_ENTRIES = 5;

  // Ranges are checked in order; the first one that matches wins.
  localparam act_range_t ACT_TABLE [TABLE_ENTRIES] = '{
    '{16'd0,   16'd50,   ACT_NONE},
    '{16'd801, 16'd1023, ACT_START},
    '{16'd600, 16'd720,  ACT_RED},
    '{16'd200, 16'd599,  ACT_BLUE},
    '{16'd721, 16'd800,  ACT_RED_BLUE}
  };

  localparam dir_range_t DIR_TABLE [TABLE_ENTRIES] = '{
    '{16'd950, 16'd1023, DIR_NONE},
    '{16'd581, 16'd750,  DIR_DOWN},
    '{16'd401, 16'd580,  DIR_RIGHT},
    '{16'd251, 16'd400,  DIR_UP},
    '{16'd100, 16'd250,  DIR_LEFT}
  };

  // First-match lookup: later entries are overridden by earlier ones.
  function automatic act_code_t decode_action(logic [LUT_W-1:0] v);
    act_code_t code;
    code = ACT_NONE;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (v >= ACT_TABLE[i].lo && v <= ACT_TABLE[i].hi) begin
        code = ACT_TABLE[i].code;
      end
    end
    return code;
  endfunction

  function automatic dir_code_t decode_direction(logic [LUT_W-1:0] v);
    dir_code_t code;
    code = DIR_NONE;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (v >= DIR_TABLE[i].lo && v <= DIR_TABLE[i].hi) begin
        code = DIR_TABLE[i].code;
      end
    end
    return code;
  endfunction

endpackage

[rtl/core/albd_if.sv]
// Valid/ready channel interfaces for samples, results and configuration writes.
interface albd_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface albd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 next_channel;
  logic                                 done_res;
  logic                                 invalid;
  logic [albd_pkg::CODE_W-1:0]          action_button;
  logic [albd_pkg::CODE_W-1:0]          direction_button;

  modport source (output valid, output next_channel, output done_res, output invalid,
                  output action_button, output direction_button, input ready);
  modport sink   (input valid, input next_channel, input done_res, input invalid,
                  input action_button, input direction_button, output ready);
endinterface

interface albd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [albd_pkg::CFG_IDX_W-1:0]  index;
  logic [albd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/albd_cfg_regs.sv]
// Configuration registers: sample count per reading and stability threshold.
module albd_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  albd_cfg_if.sink        cfg_ch,
  output albd_pkg::cfg_t  cfg
);

  albd_pkg::cfg_t cfg_r;
  albd_pkg::cfg_t cfg_nxt;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        albd_pkg::CFG_SAMPLES_PER_READ: begin
          cfg_nxt.samples_per_read = cfg_ch.data[albd_pkg::SPR_W-1:0];
        end
        albd_pkg::CFG_STABILITY_THRESHOLD: begin
          cfg_nxt.stability_threshold = cfg_ch.data[albd_pkg::THR_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_read    <= albd_pkg::SPR_RESET;
      cfg_r.stability_threshold <= albd_pkg::THR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/albd_decode.sv]
// Range-table decode of an averaged ladder voltage into action and direction codes.
module albd_decode #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic [SAMPLE_BITS-1:0] value,
  output albd_pkg::act_code_t    action,
  output albd_pkg::dir_code_t    direction
);

  logic [albd_pkg::LUT_W-1:0] value_ext;

  // Widen to the table width so the bounds compare without loss.
  assign value_ext = albd_pkg::LUT_W'(value);
  assign action    = albd_pkg::decode_action(value_ext);
  assign direction = albd_pkg::decode_direction(value_ext);

endmodule

[rtl/core/albd_track.sv]
// Input register, running-average stability check and channel sequencing.
module albd_track #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  albd_in_if.sink        in_ch,
  input  albd_pkg::cfg_t cfg,
  output logic           res_valid,
  input  logic           res_ready,
  output albd_pkg::res_t res
);

  // Input register.
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   s1_fire;
  logic                   in_fire;

  // Reading state.
  logic                           phase_r;
  logic                           phase_nxt;
  logic [albd_pkg::IDX_W-1:0]     idx_r;
  logic [albd_pkg::IDX_W-1:0]     idx_nxt;
  logic [SAMPLE_BITS-1:0]         avg_r;
  logic [SAMPLE_BITS-1:0]         avg_nxt;
  albd_pkg::act_code_t            held_r;
  albd_pkg::act_code_t            held_nxt;

  // Datapath intermediates.
  logic [albd_pkg::SPR_W-1:0] n_sat;
  logic [albd_pkg::SPR_W-1:0] idx_inc;
  logic                       last;
  logic [SAMPLE_BITS-1:0]     diff;
  logic [SAMPLE_BITS:0]       sum;
  logic [SAMPLE_BITS-1:0]     avg_upd;
  logic                       unstable;
  albd_pkg::act_code_t        act_dec;
  albd_pkg::dir_code_t        dir_dec;

  assign s1_fire     = s1_valid_r && res_ready;
  assign in_ch.ready = !s1_valid_r || res_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_ch.sample;
    end
  end

  // Sample count clamped to its legal span; the reading ends on its last sample.
  always_comb begin
    if (cfg.samples_per_read < albd_pkg::SPR_MIN) begin
      n_sat = albd_pkg::SPR_MIN;
    end else if (cfg.samples_per_read > albd_pkg::SPR_MAX) begin
      n_sat = albd_pkg::SPR_MAX;
    end else begin
      n_sat = cfg.samples_per_read;
    end
  end

  assign idx_inc = {1'b0, idx_r} + albd_pkg::SPR_W'(1);
  assign last    = idx_inc >= n_sat;

  // Distance from the average and the averaged update.
  assign diff     = (s1_sample_r > avg_r) ? (s1_sample_r - avg_r) : (avg_r - s1_sample_r);
  assign unstable = (idx_r != '0) && (diff > SAMPLE_BITS'(cfg.stability_threshold));
  assign sum      = {1'b0, s1_sample_r} + {1'b0, avg_r};
  assign avg_upd  = (idx_r == '0) ? s1_sample_r : sum[SAMPLE_BITS:1];

  albd_decode #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_decode (
    .value    (avg_upd),
    .action   (act_dec),
    .direction(dir_dec)
  );

  // Next state and the result of the current sample.
  always_comb begin
    phase_nxt            = phase_r;
    idx_nxt              = idx_r;
    avg_nxt              = unstable ? avg_r : avg_upd;
    held_nxt             = held_r;
    res.done_res         = 1'b0;
    res.invalid          = 1'b0;
    res.action_button    = albd_pkg::ACT_NONE;
    res.direction_button = albd_pkg::DIR_NONE;
    if (unstable) begin
      phase_nxt    = albd_pkg::CH_ACTION;
      idx_nxt      = '0;
      held_nxt     = albd_pkg::ACT_NONE;
      res.done_res = 1'b1;
      res.invalid  = 1'b1;
    end else if (last) begin
      idx_nxt = '0;
      if (phase_r == albd_pkg::CH_ACTION) begin
        if (act_dec == albd_pkg::ACT_START) begin
          res.done_res      = 1'b1;
          res.action_button = albd_pkg::ACT_START;
          held_nxt          = albd_pkg::ACT_NONE;
        end else begin
          held_nxt  = act_dec;
          phase_nxt = albd_pkg::CH_DIRECTION;
        end
      end else begin
        res.done_res         = 1'b1;
        res.action_button    = held_r;
        res.direction_button = dir_dec;
        phase_nxt            = albd_pkg::CH_ACTION;
        held_nxt             = albd_pkg::ACT_NONE;
      end
    end else begin
      idx_nxt = idx_r + albd_pkg::IDX_W'(1);
    end
    res.next_channel = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= albd_pkg::CH_ACTION;
      idx_r   <= '0;
      avg_r   <= '0;
      held_r  <= albd_pkg::ACT_NONE;
    end else if (s1_fire) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      avg_r   <= avg_nxt;
      held_r  <= held_nxt;
    end
  end

  assign res_valid = s1_valid_r;

endmodule

[rtl/core/albd_out_skid.sv]
// Result register with a skid stage that takes a beat under back-pressure before the tracker is held.
module albd_out_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  albd_pkg::res_t up_data,
  albd_out_if.source     out_ch
);

  logic           out_valid_r;
  albd_pkg::res_t out_data_r;
  logic           skid_valid_r;
  albd_pkg::res_t skid_data_r;
  logic           pop;
  logic           push;

  assign up_ready = !skid_valid_r;
  assign pop      = out_valid_r && out_ch.ready;
  assign push     = up_valid && up_ready;

  // Control: refill from the skid first, otherwise from the incoming beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= up_data;
      end
    end else if (push) begin
      skid_data_r <= up_data;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.next_channel     = out_data_r.next_channel;
  assign out_ch.done_res         = out_data_r.done_res;
  assign out_ch.invalid          = out_data_r.invalid;
  assign out_ch.action_button    = out_data_r.action_button;
  assign out_ch.direction_button = out_data_r.direction_button;

endmodule

[rtl/core/adc_ladder_button_decoder_top.sv]
// Top level of the resistor-ladder keypad decoder.
// Each input beat is one ADC sample of the channel named by the previous result's
// next_channel, and every sample gives exactly one result beat. A verdict reads the
// action ladder and then the direction ladder, each over samples_per_read samples
// (clamped to 2..16), keeping a running average; a sample after the first of a reading
// that lies farther than stability_threshold from the average ends the verdict at once as
// invalid, and a START press skips the direction reading. The block takes one sample
// per clock cycle while the result side accepts; a result is held in the input register
// and then in the result register, with the compare, add-shift and range-table decode
// in the single logic stage between them. A skid register ahead of the result register
// takes a beat while the result register is held; the tracker is held once it is full.
module adc_ladder_button_decoder_top #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  albd_in_if.sink    in_ch,
  albd_out_if.source out_ch,
  albd_cfg_if.sink   cfg_ch
);

  albd_pkg::cfg_t cfg;
  albd_pkg::res_t res;
  logic           res_valid;
  logic           res_ready;

  // Configuration registers.
  albd_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .cfg   (cfg)
  );

  // Sample tracking and decode.
  albd_track #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Result register and skid stage.
  albd_out_skid u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(res_valid),
    .up_ready(res_ready),
    .up_data (res),
    .out_ch  (out_ch)
  );

endmodule
